// ----- hdl/kmp_pkg.sv -----
// Shared types and constants for the KMP pattern matcher.
`timescale 1ns / 1ps

package kmp_pkg;

   localparam int MaxPatternDefault   = 64;
   localparam int PositionBitsDefault = 32;
   localparam int MatchBits           = 32;
   localparam int ByteBits            = 8;

   typedef logic [ByteBits-1:0]  byte_type;
   typedef logic [MatchBits-1:0] match_type;

   localparam logic CMD_PATTERN = 1'b0;
   localparam logic CMD_TEXT    = 1'b1;

   // Control broadcast to every cell of the row.
   typedef struct packed {
      logic load;   // shift a pattern byte into the row
      logic step;   // match a text byte against a closed pattern
      logic fresh;  // text byte starts a new text
   } cell_ctrl_type;

endpackage

// ----- hdl/kmp_chan_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
`timescale 1ns / 1ps

interface kmp_req_if;
   import kmp_pkg::*;

   logic     valid;
   logic     ready;
   logic     command;
   byte_type byte_value;
   logic     pattern_end;
   logic     new_text;

   modport source (output valid, output command, output byte_value, output pattern_end,
                   output new_text, input ready);
   modport sink   (input valid, input command, input byte_value, input pattern_end,
                   input new_text, output ready);
endinterface

interface kmp_rsp_if;
   import kmp_pkg::*;

   logic      valid;
   logic      ready;
   match_type match_start;

   modport source (output valid, output match_start, input ready);
   modport sink   (input valid, input match_start, output ready);
endinterface

// ----- hdl/kmp_cell.sv -----
// One cell of the matcher row: a pattern byte and one partial-match bit.
`timescale 1ns / 1ps

module kmp_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  kmp_pkg::cell_ctrl_type ctrl,
   input  kmp_pkg::byte_type      text_byte,
   input  kmp_pkg::byte_type      load_byte,
   input  logic                   load_valid,
   input  logic                   chain_in,
   output kmp_pkg::byte_type      char_out,
   output logic                   valid_out,
   output logic                   chain_out,
   output logic                   hit
);
   import kmp_pkg::*;

   byte_type char_ff;
   logic     valid_ff;
   logic     state_ff;

   // The pattern prefix ending at this cell's byte matches the text ending at the current byte.
   assign hit       = valid_ff && (text_byte == char_ff) && chain_in;
   // A cell past the end of the pattern passes an unconditional match.
   assign chain_out = valid_ff ? (state_ff && !ctrl.fresh) : 1'b1;
   assign char_out  = char_ff;
   assign valid_out = valid_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         char_ff <= load_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         state_ff <= 1'b0;
      end else if (ctrl.load) begin
         valid_ff <= load_valid;
         state_ff <= 1'b0;
      end else if (ctrl.step) begin
         state_ff <= hit;
      end
   end

endmodule

// ----- hdl/kmp_rsp_queue.sv -----
// Two-entry response queue that decouples the cell row from the result sink.
`timescale 1ns / 1ps

module kmp_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  kmp_pkg::match_type push_data,
   output logic               space,
   kmp_rsp_if.source          rsp_chan
);
   import kmp_pkg::*;

   match_type  slot_ff [2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       rd_ff;
   logic       rd_in;
   logic       wr_idx;
   logic       pop;

   assign pop                  = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.valid       = count_ff != 2'd0;
   assign rsp_chan.match_start = slot_ff[rd_ff];
   assign space                = count_ff != 2'd2;
   assign wr_idx               = rd_ff ^ count_ff[0];
   assign rd_in                = pop ? !rd_ff : rd_ff;

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_idx] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (space || pop))
      else $error("response queue overflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("response queue count out of range");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("response queue count did not drop on pop");

endmodule

// ----- hdl/kmp_pattern_matcher.sv -----
// Top level of the KMP pattern matcher: cell row, text position and output queue.
`timescale 1ns / 1ps

// Pattern bytes shift into a row of MAX_PATTERN cells, the last pattern byte in
// cell 0; each cell holds one pattern byte and one partial-match bit that it
// hands to its neighbor toward cell 0 on every text byte, and a full match is
// seen at cell 0 in the cycle the completing text byte is accepted. Every item,
// pattern or text, is handled as it is accepted; closing a pattern adds no step.
// Items are accepted while the two-entry response queue has room, so a stalled
// result sink holds off the request side only once two results are waiting. A
// result leaves the queue in the cycle after its item at the earliest. Text
// position saturates at 2^POSITION_BITS - 1; match_start is the low 32 bits of
// the start offset, clamped at zero. There is no clearing pass after reset.
module kmp_pattern_matcher #(
   parameter int MAX_PATTERN   = kmp_pkg::MaxPatternDefault,
   parameter int POSITION_BITS = kmp_pkg::PositionBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   kmp_req_if.sink   req_chan,
   kmp_rsp_if.source rsp_chan
);
   import kmp_pkg::*;

   localparam int SizeW = $clog2(MAX_PATTERN + 1);
   localparam int CmpW  = (POSITION_BITS > SizeW) ? POSITION_BITS : SizeW;
   localparam int ExtW  = (CmpW > MatchBits) ? CmpW : MatchBits;
   localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

   logic [SizeW-1:0]         size_ff;
   logic [SizeW-1:0]         size_in;
   logic                     closed_ff;
   logic                     closed_in;
   logic [POSITION_BITS-1:0] pos_ff;
   logic [POSITION_BITS-1:0] pos_in;
   logic [POSITION_BITS-1:0] pos_base;

   logic          accept;
   logic          is_text;
   logic          has_room;
   logic          space;
   logic          push;
   cell_ctrl_type ctrl;

   byte_type char_link  [MAX_PATTERN];
   logic     valid_link [MAX_PATTERN];
   logic     hit_link   [MAX_PATTERN];
   logic     chain_link [MAX_PATTERN+1];

   logic [CmpW-1:0] pos_wide;
   logic [CmpW-1:0] back_wide;
   logic [CmpW-1:0] start_wide;
   logic [ExtW-1:0] start_ext;

   assign req_chan.ready = space;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_text        = req_chan.command == CMD_TEXT;
   assign has_room       = size_ff < SizeW'(MAX_PATTERN);

   assign ctrl.load  = accept && !is_text && (closed_ff || has_room);
   assign ctrl.step  = accept && is_text && closed_ff;
   assign ctrl.fresh = req_chan.new_text;

   assign chain_link[MAX_PATTERN] = 1'b1;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      byte_type load_byte;
      logic     load_valid;

      if (k == 0) begin : g_head
         assign load_byte  = req_chan.byte_value;
         assign load_valid = 1'b1;
      end else begin : g_body
         // A byte that starts a new pattern drops the old one from the row.
         assign load_byte  = char_link[k-1];
         assign load_valid = valid_link[k-1] && !closed_ff;
      end

      kmp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .text_byte  (req_chan.byte_value),
         .load_byte  (load_byte),
         .load_valid (load_valid),
         .chain_in   (chain_link[k+1]),
         .char_out   (char_link[k]),
         .valid_out  (valid_link[k]),
         .chain_out  (chain_link[k]),
         .hit        (hit_link[k])
      );
   end

   // Position of this text byte within the current text.
   assign pos_base   = req_chan.new_text ? '0 : pos_ff;
   assign pos_in     = (pos_base < PosMax) ? pos_base + 1'b1 : pos_base;
   assign pos_wide   = CmpW'(pos_base);
   assign back_wide  = CmpW'(size_ff - 1'b1);
   assign start_wide = (pos_wide >= back_wide) ? pos_wide - back_wide : '0;
   assign start_ext  = ExtW'(start_wide);

   assign push = ctrl.step && hit_link[0];

   always_comb begin
      size_in   = size_ff;
      closed_in = closed_ff;
      if (accept && !is_text) begin
         if (closed_ff) begin
            size_in = SizeW'(1);
         end else if (has_room) begin
            size_in = size_ff + 1'b1;
         end
         closed_in = req_chan.pattern_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= '0;
         closed_ff <= 1'b0;
         pos_ff    <= '0;
      end else begin
         size_ff   <= size_in;
         closed_ff <= closed_in;
         if (accept && is_text) begin
            pos_ff <= pos_in;
         end
      end
   end

   kmp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (start_ext[MatchBits-1:0]),
      .space     (space),
      .rsp_chan  (rsp_chan)
   );

   a_closed_nonempty: assert property (@(posedge clock) disable iff (reset)
      closed_ff |-> (size_ff != '0))
      else $error("closed pattern has no bytes");

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      size_ff <= SizeW'(MAX_PATTERN))
      else $error("pattern size beyond row length");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      (size_ff != '0) |-> valid_link[0])
      else $error("head cell empty with a pattern loaded");

   a_push_closed: assert property (@(posedge clock) disable iff (reset)
      push |-> (closed_ff && is_text && accept))
      else $error("match reported without a closed pattern");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the KMP pattern matcher: directed rows, then random traffic.
`timescale 1ns / 1ps

module tb;
   import kmp_pkg::*;

   localparam int PatDepth    = MaxPatternDefault;
   localparam int PosBits     = PositionBitsDefault;
   localparam int ItemTarget  = 1150;
   localparam int CalmTail    = 150;
   localparam int CycleLimit  = 250000;
   localparam int SettleTicks = 10;

   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_AT} row_check_type;

   typedef struct packed {
      logic     command;
      byte_type value;
      logic     last;
      logic     fresh;
   } req_item_type;

   localparam int ItemBits = $bits(req_item_type);

   typedef struct packed {
      req_item_type  item;
      row_check_type chk;
      match_type     at;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   kmp_req_if req_chan ();
   kmp_rsp_if rsp_chan ();

   kmp_pattern_matcher dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state
   byte_type               pat_bytes [PatDepth];
   int unsigned            borders [PatDepth];
   int unsigned            pat_len = 0;
   bit                     pat_closed = 1'b0;
   int unsigned            run_len = 0;
   logic [PosBits-1:0]     text_pos = '0;

   match_type   expected_starts [$];
   int unsigned errors = 0;
   int unsigned sent = 0;
   longint      cycles = 0;
   bit          idle_on = 1'b0;
   int          stall_left = 0;

   // Advance the matcher state by one item; return 1 with the start offset on a full match.
   function automatic bit step_matcher(input req_item_type it, output match_type start);
      int unsigned k;
      int unsigned q;
      logic [PosBits-1:0] back;
      bit found;
      found = 1'b0;
      start = '0;
      if (it.command == CMD_PATTERN) begin
         if (pat_closed) begin
            pat_len = 0;
            pat_closed = 1'b0;
         end
         run_len = 0;
         if (pat_len < PatDepth) begin
            pat_bytes[pat_len] = it.value;
            pat_len++;
         end
         if (it.last) begin
            // rebuild the border lengths over the stored pattern
            k = 0;
            q = 1;
            borders[0] = 0;
            while (q < pat_len) begin
               if (pat_bytes[q] == pat_bytes[k]) begin
                  k++;
                  borders[q] = k;
                  q++;
               end else if (k != 0) begin
                  k = borders[k-1];
               end else begin
                  borders[q] = 0;
                  q++;
               end
            end
            pat_closed = 1'b1;
            run_len = 0;
         end
         return 1'b0;
      end
      if (it.fresh) begin
         text_pos = '0;
         run_len = 0;
      end
      if (pat_closed && pat_len > 0) begin
         if (run_len >= pat_len)
            run_len = 0;
         while (run_len > 0 && pat_bytes[run_len] != it.value)
            run_len = borders[run_len-1];
         if (pat_bytes[run_len] == it.value)
            run_len++;
         if (run_len == pat_len) begin
            back = PosBits'(pat_len - 1);
            start = match_type'((text_pos >= back) ? text_pos - back : '0);
            found = 1'b1;
            run_len = borders[pat_len-1];
         end
      end
      if (text_pos != '1)
         text_pos++;
      return found;
   endfunction

   // Offer one item, wait for it to be taken, then record what it should produce.
   task automatic send_item(input req_item_type it, input row_check_type chk,
                            input match_type at);
      match_type start;
      bit found;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.command     <= it.command;
      req_chan.byte_value  <= it.value;
      req_chan.pattern_end <= it.last;
      req_chan.new_text    <= it.fresh;
      do @(posedge clock); while (!req_chan.ready);
      found = step_matcher(it, start);
      case (chk)
         CHK_MODEL: begin
            if (found)
               expected_starts = {expected_starts, start};
         end
         CHK_AT: expected_starts = {expected_starts, at};
         default: ;
      endcase
      sent++;
   endtask

   // Hold the sender until every outstanding result has drained.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_starts.size() != 0);
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("tb failed");
         $finish;
      end
   end

   // Result side: check each item taken, then pick ready for the next cycle.
   initial begin
      match_type want;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_starts.size() == 0) begin
               errors++;
               $display("%0t: match_start expected none, got %0d", $time,
                        rsp_chan.match_start);
            end else begin
               want = expected_starts.pop_front();
               if (rsp_chan.match_start !== want) begin
                  errors++;
                  $display("%0t: match_start expected %0d, got %0d", $time, want,
                           rsp_chan.match_start);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      dir_row_type  directed_rows [18];
      req_item_type it;
      byte_type     alpha [3];
      byte_type     pat_src [$];
      int           alpha_n;
      int           len;
      int           text_n;
      int           copy_n;
      int           pick;
      bit           first_pass;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.command     <= CMD_PATTERN;
      req_chan.byte_value  <= '0;
      req_chan.pattern_end <= 1'b0;
      req_chan.new_text    <= 1'b0;

      directed_rows = '{
         // text before any pattern: position advances, nothing reported
         '{'{CMD_TEXT,    8'h61, 1'b0, 1'b1}, CHK_NONE,  32'd0},
         '{'{CMD_PATTERN, 8'h61, 1'b1, 1'b0}, CHK_NONE,  32'd0},
         // closing keeps the position
         '{'{CMD_TEXT,    8'h61, 1'b0, 1'b0}, CHK_AT,    32'd1},
         '{'{CMD_TEXT,    8'h61, 1'b0, 1'b1}, CHK_AT,    32'd0},
         // new pattern after a closed one, byte extremes
         '{'{CMD_PATTERN, 8'h00, 1'b0, 1'b0}, CHK_NONE,  32'd0},
         '{'{CMD_PATTERN, 8'hFF, 1'b0, 1'b1}, CHK_NONE,  32'd0},
         '{'{CMD_PATTERN, 8'h00, 1'b1, 1'b0}, CHK_NONE,  32'd0},
         '{'{CMD_TEXT,    8'h00, 1'b0, 1'b1}, CHK_NONE,  32'd0},
         '{'{CMD_TEXT,    8'hFF, 1'b0, 1'b0}, CHK_NONE,  32'd0},
         '{'{CMD_TEXT,    8'h00, 1'b0, 1'b0}, CHK_AT,    32'd0},
         // overlapping occurrence
         '{'{CMD_TEXT,    8'hFF, 1'b0, 1'b0}, CHK_NONE,  32'd0},
         '{'{CMD_TEXT,    8'h00, 1'b0, 1'b0}, CHK_AT,    32'd2},
         // pattern_end on a text byte is ignored
         '{'{CMD_TEXT,    8'h00, 1'b1, 1'b0}, CHK_MODEL, 32'd0},
         // new_text on a pattern byte is ignored; text while open
         '{'{CMD_PATTERN, 8'h61, 1'b0, 1'b1}, CHK_NONE,  32'd0},
         '{'{CMD_TEXT,    8'h61, 1'b0, 1'b0}, CHK_NONE,  32'd0},
         '{'{CMD_PATTERN, 8'h62, 1'b1, 1'b0}, CHK_NONE,  32'd0},
         '{'{CMD_TEXT,    8'h61, 1'b0, 1'b0}, CHK_NONE,  32'd0},
         '{'{CMD_TEXT,    8'h62, 1'b0, 1'b0}, CHK_AT,    32'd7}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_on = 1'b1;
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].chk, directed_rows[i].at);

      first_pass = 1'b1;
      while (sent < ItemTarget) begin
         idle_on = (sent < ItemTarget - CalmTail) && ($urandom_range(0, 3) != 0);
         if (first_pass || $urandom_range(0, 11) == 0)
            drain_results();
         first_pass = 1'b0;

         alpha_n = $urandom_range(1, 3);
         foreach (alpha[i])
            alpha[i] = byte_type'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);

         if (pick < 78) begin
            // well-formed: load a pattern, then a text seeded with copies of it
            pick = $urandom_range(0, 99);
            if (pick < 85)
               len = $urandom_range(1, 6);
            else if (pick < 96)
               len = $urandom_range(7, PatDepth);
            else
               len = $urandom_range(PatDepth + 1, PatDepth + 8);
            pat_src.delete();
            for (int i = 0; i < len; i++) begin
               it.command = CMD_PATTERN;
               it.value   = alpha[$urandom_range(0, alpha_n - 1)];
               it.last    = (i == len - 1);
               it.fresh   = 1'($urandom_range(0, 1));
               if (i < PatDepth)
                  pat_src = {pat_src, it.value};
               send_item(it, CHK_MODEL, '0);
            end
            text_n = $urandom_range(10, 40);
            for (int i = 0; i < text_n; i++) begin
               if ($urandom_range(0, 3) == 0) begin
                  copy_n = pat_src.size();
                  i += copy_n - 1;
               end else begin
                  copy_n = 0;
               end
               it.command = CMD_TEXT;
               it.last    = 1'($urandom_range(0, 1));
               it.fresh   = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 29) == 0);
               if (copy_n > 0) begin
                  foreach (pat_src[j]) begin
                     it.value = pat_src[j];
                     if (j > 0)
                        it.fresh = 1'b0;
                     send_item(it, CHK_MODEL, '0);
                  end
               end else begin
                  it.value = alpha[$urandom_range(0, alpha_n - 1)];
                  send_item(it, CHK_MODEL, '0);
               end
            end
         end else if (pick < 90) begin
            // noise: any field value at all
            repeat ($urandom_range(5, 15)) begin
               it = req_item_type'(ItemBits'($urandom_range(0, 2047)));
               send_item(it, CHK_MODEL, '0);
            end
         end else begin
            // broken: pattern left open, text streams past it
            repeat ($urandom_range(1, 5)) begin
               it.command = CMD_PATTERN;
               it.value   = alpha[$urandom_range(0, alpha_n - 1)];
               it.last    = 1'b0;
               it.fresh   = 1'($urandom_range(0, 1));
               send_item(it, CHK_MODEL, '0);
            end
            repeat ($urandom_range(3, 12)) begin
               it.command = CMD_TEXT;
               it.value   = alpha[$urandom_range(0, alpha_n - 1)];
               it.last    = 1'($urandom_range(0, 1));
               it.fresh   = 1'($urandom_range(0, 1));
               send_item(it, CHK_MODEL, '0);
            end
         end
      end

      idle_on = 1'b0;
      drain_results();
      repeat (SettleTicks) @(posedge clock);
      if (errors == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/kmp_pkg.sv
hdl/kmp_chan_if.sv
hdl/kmp_cell.sv
hdl/kmp_rsp_queue.sv
hdl/kmp_pattern_matcher.sv
test/tb.sv
